[rtl/tpq_pkg.sv]
// ----------------------------------------------------------------------------
// tpq_pkg: shared types for the two-level priority task queue
// Entry layout, command and status codes, and the ordering rule used by
// the sorting cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  typedef struct packed {
    logic [15:0]        handle;
    logic               crit;
    logic signed [15:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_PLAN   = 2'd1,
    CMD_EXEC   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Row-wide control broadcast from the controller to every cell.
  typedef struct packed {
    logic load;   // append the new entry at the cell whose index is the count
    logic shift;  // every cell takes its right neighbor (head removal)
    logic sort;   // a transposition pass is running
    logic odd;    // pass parity: pairs start at odd cells
  } ctl_t;

  // True when a must be served strictly before b. Equal keys never swap,
  // which keeps the sort stable.
  function automatic logic goes_before(input entry_t a, input entry_t b);
    logic res;
    if (a.crit != b.crit) begin
      res = a.crit;
    end else begin
      res = (a.prio > b.prio);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/tpq_cell.sv]
// ----------------------------------------------------------------------------
// tpq_cell: one slot of the queue
// Holds one entry. Loads a new entry, shifts toward the head, or swaps
// with a neighbor during an odd-even transposition pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_cell import tpq_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire logic          clk,
  input  wire ctl_t          ctl,
  input  wire logic [CW-1:0] count,
  input  wire entry_t        din,
  input  wire entry_t        left_ent,
  input  wire entry_t        right_ent,
  input  wire logic          swap_left,
  output logic               swap_right,
  output entry_t             ent
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);
  localparam logic          MY_PAR   = 1'(IDX % 2);

  entry_t ent_next;

  // This cell owns the pair (IDX, IDX+1) on passes of its parity.
  assign swap_right = ctl.sort && (ctl.odd == MY_PAR) && (NEXT_IDX < count) &&
                      goes_before(right_ent, ent);

  always_comb begin
    ent_next = ent;
    if (ctl.load && (count == MY_IDX)) begin
      ent_next = din;
    end else if (ctl.shift || swap_right) begin
      ent_next = right_ent;
    end else if (swap_left) begin
      ent_next = left_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

[rtl/tpq_ctrl.sv]
// ----------------------------------------------------------------------------
// tpq_ctrl: command decoder and sort sequencer
// Keeps the entry count, decodes each beat and runs count transposition
// passes over the cell row when a plan is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ctrl import tpq_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [1:0]    cmd,
  input  wire logic          critical,
  output ctl_t               ctl,
  output logic [CW-1:0]      count,
  output logic [CW-1:0]      count_next,
  output status_t            res_status,
  output logic               busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SORT = 2'b10
  } state_t;

  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_t        state;
  logic [CW-1:0] pass;
  logic          phase;
  logic          start;

  always_comb begin
    count_next = count;
    res_status = ST_OK;
    ctl.load   = 1'b0;
    ctl.shift  = 1'b0;
    ctl.sort   = (state == S_SORT);
    ctl.odd    = phase;
    start      = 1'b0;
    if (accept) begin
      unique case (cmd_t'(cmd))
        CMD_SUBMIT: begin
          if (count == FULL) begin
            res_status = ST_FULL;
          end else begin
            ctl.load   = 1'b1;
            count_next = count + CW'(1);
            // A critical submit plans once there are two or more entries.
            start      = critical && (count != '0);
          end
        end
        CMD_PLAN: begin
          start = (count >= CW'(2));
        end
        CMD_EXEC: begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else begin
            ctl.shift  = 1'b1;
            count_next = count - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pass  <= '0;
      phase <= 1'b0;
    end else begin
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SORT;
            pass  <= '0;
            phase <= 1'b0;
          end
        end
        S_SORT: begin
          phase <= ~phase;
          pass  <= pass + CW'(1);
          // As many passes as entries fully sort the row.
          if (pass == count - CW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/two_level_priority_task_queue_unit.sv]
// ----------------------------------------------------------------------------
// two_level_priority_task_queue_unit: stable two-level priority task queue
// Holds up to DEPTH tasks in a row of cells; critical tasks go first, then
// higher Q8.8 priority, and equal keys keep their arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (cmd, task_id, critical, priority_req) are taken when
//   in_valid is high and in_stall is low. Every input beat yields exactly
//   one output beat (status, task fields, entry_count), held in an output
//   register until taken with out_valid high and out_stall low.
//   The output beat is registered and appears in the cycle after the input
//   beat is taken. A plan, and a submit of a critical task, then runs an
//   odd-even transposition sort over the cell row, one pass per cycle and
//   as many passes as stored entries (up to DEPTH) when two or more are
//   stored; with fewer no sort runs. in_stall is high during the sort and
//   while a finished output beat is stalled.
//   Reset empties the queue and drops any pending output beat; the cell
//   contents are not cleared since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_priority_task_queue_unit import tpq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         cmd,
  input  wire logic [15:0]        task_id,
  input  wire logic               critical,
  input  wire logic signed [15:0] priority_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic                    task_valid,
  output logic [15:0]             task_out,
  output logic                    critical_out,
  output logic signed [15:0]      priority_out,
  output logic [6:0]              entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  ctl_t          ctl;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  status_t       res_status;
  logic          busy;
  logic          accept;
  entry_t        new_ent;
  entry_t        ent  [DEPTH];
  logic          swp  [DEPTH];

  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign new_ent.handle = task_id;
  assign new_ent.crit   = critical;
  assign new_ent.prio   = priority_req;

  tpq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (cmd),
    .critical   (critical),
    .ctl        (ctl),
    .count      (count),
    .count_next (count_next),
    .res_status (res_status),
    .busy       (busy)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   swap_left;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign swap_left = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign swap_left = swp[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    tpq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .din        (new_ent),
      .left_ent   (left_ent),
      .right_ent  (right_ent),
      .swap_left  (swap_left),
      .swap_right (swp[i]),
      .ent        (ent[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // The head cell still holds the removed entry at the accepting edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      task_valid   <= ctl.shift;
      task_out     <= ctl.shift ? ent[0].handle : 16'd0;
      critical_out <= ctl.shift ? ent[0].crit : 1'b0;
      priority_out <= ctl.shift ? ent[0].prio : 16'sd0;
      entry_count  <= 7'(count_next);
    end
  end

endmodule

`default_nettype wire

[rtl/tpq_checker.sv]
// ----------------------------------------------------------------------------
// tpq_checker: port-level checks for the task queue
// Watches the top-level ports and flags inconsistent output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_checker import tpq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic               task_valid,
  input wire logic [15:0]        task_out,
  input wire logic               critical_out,
  input wire logic signed [15:0] priority_out,
  input wire logic [6:0]         entry_count
);

  // Every input beat produces an output beat in the next cycle.
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("input beat without output beat");

  // A stalled output beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(task_out) && $stable(entry_count)))
    else $error("stalled output beat changed");

  // A returned task always reports success.
  a_task_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && task_valid) |-> (status == ST_OK))
    else $error("returned task with error status");

  // A dropped submit only happens with a full queue.
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (entry_count == 7'(DEPTH)))
    else $error("full status with room left");

  // Without a returned task the task fields read as zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !task_valid) |->
      ((task_out == 16'd0) && !critical_out && (priority_out == 16'sd0)))
    else $error("task fields set without a returned task");

endmodule

bind two_level_priority_task_queue_unit tpq_checker #(.DEPTH(DEPTH)) u_tpq_checker (.*);

`default_nettype wire

[verif/tb_two_level_priority_task_queue_unit.sv]
// ----------------------------------------------------------------------------
// tb_two_level_priority_task_queue_unit: self-checking bench for the task queue
// A queue of command beats feeds a clocked driver. A clocked monitor checks
// every result beat against a stable-sort model of the queue that is kept
// inside the bench. Handshake idling runs in phases on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_two_level_priority_task_queue_unit;
  import tpq_pkg::*;

  localparam int          QUEUE_DEPTH  = 64;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          SETTLE_TIME  = 2 * QUEUE_DEPTH + 8;
  localparam int          RANDOM_ITEMS = 1400;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct {
    logic [1:0]         cmd;
    logic [15:0]        id;
    logic               crit;
    logic signed [15:0] prio;
    bit                 drain;   // hold this beat until all results are back
    int                 phase;
  } beat_t;

  typedef struct {
    logic [1:0]         status;
    logic               task_valid;
    logic [15:0]        task_out;
    logic               critical_out;
    logic signed [15:0] priority_out;
    logic [6:0]         entry_count;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = CMD_SUBMIT;
  logic [15:0]        task_id = '0;
  logic               critical = 1'b0;
  logic signed [15:0] priority_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         status;
  logic               task_valid;
  logic [15:0]        task_out;
  logic               critical_out;
  logic signed [15:0] priority_out;
  logic [6:0]         entry_count;

  beat_t    pending_beats[$];
  outcome_t expected_results[$];
  entry_t   queued_tasks[$];
  int       gen_count;
  int       error_count = 0;
  int       cycle_count = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;

  two_level_priority_task_queue_unit #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .task_id(task_id), .critical(critical), .priority_req(priority_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .task_valid(task_valid), .task_out(task_out),
    .critical_out(critical_out), .priority_out(priority_out),
    .entry_count(entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Critical first, then strictly higher priority; equal keys never overtake.
  function automatic bit served_ahead(entry_t a, entry_t b);
    if (a.crit != b.crit) begin
      return a.crit;
    end
    return a.prio > b.prio;
  endfunction

  function automatic void reorder_tasks();
    int     i;
    int     j;
    entry_t cur;
    for (i = 1; i < queued_tasks.size(); i++) begin
      cur = queued_tasks[i];
      j = i;
      while (j > 0 && served_ahead(cur, queued_tasks[j - 1])) begin
        queued_tasks[j] = queued_tasks[j - 1];
        j--;
      end
      queued_tasks[j] = cur;
    end
  endfunction

  function automatic outcome_t queue_outcome(logic [1:0] c, logic [15:0] id, logic crit,
                                             logic signed [15:0] prio);
    outcome_t r;
    entry_t   e;
    r = '{status: ST_OK, task_valid: 1'b0, task_out: '0, critical_out: 1'b0,
          priority_out: '0, entry_count: '0};
    case (c)
      CMD_SUBMIT: begin
        if (queued_tasks.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.handle = id;
          e.crit = crit;
          e.prio = prio;
          queued_tasks.push_back(e);
          if (crit) begin
            reorder_tasks();
          end
        end
      end
      CMD_PLAN: begin
        reorder_tasks();
      end
      CMD_EXEC: begin
        if (queued_tasks.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e = queued_tasks.pop_front();
          r.task_valid = 1'b1;
          r.task_out = e.handle;
          r.critical_out = e.crit;
          r.priority_out = e.prio;
        end
      end
      default: begin
      end
    endcase
    r.entry_count = 7'(queued_tasks.size());
    return r;
  endfunction

  // Driver: predicts each accepted beat, then presents the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(queue_outcome(cmd, task_id, critical, priority_req));
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 &&
            (!pending_beats[0].drain || expected_results.size() == 0) &&
            $urandom_range(0, 99) >= idle_pct) begin
          cmd <= pending_beats[0].cmd;
          task_id <= pending_beats[0].id;
          critical <= pending_beats[0].crit;
          priority_req <= pending_beats[0].prio;
          case (pending_beats[0].phase)
            1: begin idle_pct <= 58; stall_pct <= 0; end
            2: begin idle_pct <= 0; stall_pct <= 58; end
            3: begin idle_pct <= 32; stall_pct <= 32; end
            default: begin idle_pct <= 0; stall_pct <= 0; end
          endcase
          in_valid <= 1'b1;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            error_count++;
          end
          if (task_valid !== exp_r.task_valid) begin
            $error("task_valid: expected %0d, got %0d", exp_r.task_valid, task_valid);
            error_count++;
          end
          if (task_out !== exp_r.task_out) begin
            $error("task_out: expected %h, got %h", exp_r.task_out, task_out);
            error_count++;
          end
          if (critical_out !== exp_r.critical_out) begin
            $error("critical_out: expected %0d, got %0d", exp_r.critical_out, critical_out);
            error_count++;
          end
          if (priority_out !== exp_r.priority_out) begin
            $error("priority_out: expected %0d, got %0d", exp_r.priority_out, priority_out);
            error_count++;
          end
          if (entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Generator side: gen_count follows the queue size so that sequences can
  // aim at the full and empty ends.
  function automatic void add_beat(logic [1:0] c, logic [15:0] id, logic crit,
                                   logic signed [15:0] prio, bit drain, int phase);
    beat_t b;
    b = '{cmd: c, id: id, crit: crit, prio: prio, drain: drain, phase: phase};
    pending_beats.push_back(b);
    if (c == CMD_SUBMIT && gen_count < QUEUE_DEPTH) begin
      gen_count++;
    end else if (c == CMD_EXEC && gen_count > 0) begin
      gen_count--;
    end
  endfunction

  function automatic logic signed [15:0] pick_priority();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return $signed(16'($urandom_range(0, 2) * 256)) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_submit(int crit_pct, bit drain, int phase);
    add_beat(CMD_SUBMIT, 16'($urandom_range(0, 65535)), $urandom_range(0, 99) < crit_pct,
             pick_priority(), drain, phase);
  endfunction

  initial begin
    int  n;
    int  k;
    int  phase;
    bit  hold;
    bit  filled_once;
    gen_count = 0;
    hold = 1'b0;
    filled_once = 1'b0;

    // Empty-queue corner cases.
    add_beat(CMD_EXEC, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    add_beat(CMD_PLAN, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    add_beat(CMD_UNUSED, 16'hffff, 1'b1, 16'sh7fff, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'h0000, 1'b0, 16'sh8000, 1'b0, 0);
    // A plan over a single entry leaves it alone.
    add_beat(CMD_PLAN, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'hffff, 1'b0, 16'sh7fff, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'h1234, 1'b0, 16'sh7fff, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'h00a5, 1'b0, 16'sd0, 1'b0, 0);
    add_beat(CMD_PLAN, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    // Critical submits sort on their own, and equal keys keep arrival order.
    add_beat(CMD_SUBMIT, 16'h5a5a, 1'b1, 16'sh8000, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'h0f0f, 1'b1, 16'sh8000, 1'b0, 0);
    add_beat(CMD_SUBMIT, 16'h8001, 1'b1, 16'sh7fff, 1'b0, 0);
    add_beat(CMD_UNUSED, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    for (k = 0; k < 9; k++) begin
      add_beat(CMD_EXEC, 16'h0000, 1'b0, 16'sd0, 1'b0, 0);
    end

    // Random part: mostly submit and removal bursts with random content,
    // with fills to the full queue, plans and noise in between.
    while (pending_beats.size() < RANDOM_ITEMS + 25) begin
      phase = (pending_beats.size() / 110) % 4;
      if (!filled_once || $urandom_range(0, 39) == 0) begin
        filled_once = 1'b1;
        while (gen_count < QUEUE_DEPTH) begin
          add_submit(8, hold, phase);
          hold = 1'b0;
        end
        // Submits to a full queue are dropped, critical ones included.
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
          add_submit(50, 1'b0, phase);
        end
        add_beat(CMD_PLAN, 16'($urandom), 1'($urandom), 16'($urandom), 1'b0, phase);
        while (gen_count > 0) begin
          add_beat(CMD_EXEC, 16'($urandom), 1'($urandom), 16'($urandom), 1'b0, phase);
        end
        add_beat(CMD_EXEC, 16'($urandom), 1'($urandom), 16'($urandom), 1'b0, phase);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
              add_submit(20, hold, phase);
              hold = 1'b0;
            end
          end
          4: begin
            add_beat(CMD_PLAN, 16'($urandom), 1'($urandom), 16'($urandom), hold, phase);
            hold = 1'b0;
          end
          5, 6: begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) begin
              add_beat(CMD_EXEC, 16'($urandom), 1'($urandom), 16'($urandom), hold, phase);
              hold = 1'b0;
            end
          end
          7, 8: begin
            add_beat(CMD_UNUSED, 16'($urandom), 1'($urandom), 16'($urandom), hold, phase);
            hold = 1'b0;
          end
          default: begin
            hold = 1'b1;
          end
        endcase
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() > 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TIME) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
